// ===== hw/rtl/csbf_pkg.sv =====
package csbf_pkg;

    localparam int DEF_NUM_SEMAPHORES = 8;
    localparam int DEF_QUEUE_DEPTH    = 8;

    // sem_index is zero-extended to this width before range check and select
    localparam int IDX_EXT_W = 7;

    localparam logic [7:0] COUNT_MAX        = 8'd255;
    localparam logic [7:0] INIT_COUNT_RESET = 8'd1;

    localparam logic KIND_WAIT   = 1'b0;
    localparam logic KIND_SIGNAL = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_HANDOFF   = 3'd2,
        ST_INCREMENT = 3'd3,
        ST_FULL      = 3'd4,
        ST_SATURATED = 3'd5
    } csbf_status_t;

    typedef struct packed {
        logic         st_write;
        logic         q_write;
        logic         q_read;
        csbf_status_t status;
    } csbf_ctrl_t;

endpackage

// ===== hw/rtl/csbf_state_mem.sv =====
module csbf_state_mem #(
    parameter int NUM_SEMAPHORES = csbf_pkg::DEF_NUM_SEMAPHORES,
    parameter int QUEUE_DEPTH    = csbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [7:0]                             cfg_data,
    input  logic                                   rd_en,
    input  logic [$clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2)-1:0] rd_idx,
    output logic [7:0]                             rd_cnt,
    output logic [$clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2)-1:0] rd_head,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]     rd_fill,
    input  logic                                   wr_en,
    input  logic [$clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2)-1:0] wr_idx,
    input  logic [7:0]                             wr_cnt,
    input  logic [$clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2)-1:0] wr_head,
    input  logic [$clog2(QUEUE_DEPTH + 1)-1:0]     wr_fill
);

    localparam int HW = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]                init_reg;
    logic [NUM_SEMAPHORES-1:0] valid_reg;

    logic [7:0]    cnt_mem  [NUM_SEMAPHORES];
    logic [HW-1:0] head_mem [NUM_SEMAPHORES];
    logic [FW-1:0] fill_mem [NUM_SEMAPHORES];

    logic [7:0]    rd_cnt_reg;
    logic [HW-1:0] rd_head_reg;
    logic [FW-1:0] rd_fill_reg;

    // Invalid entries read as a freshly loaded semaphore; a config write reloads the bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= csbf_pkg::INIT_COUNT_RESET;
            valid_reg <= '0;
        end
        else if (cfg_we)
        begin
            init_reg  <= cfg_data;
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_idx]  <= wr_cnt;
            head_mem[wr_idx] <= wr_head;
            fill_mem[wr_idx] <= wr_fill;
        end
    end

    // Forward a same-edge update so a back-to-back request sees fresh state
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                rd_cnt_reg  <= wr_cnt;
                rd_head_reg <= wr_head;
                rd_fill_reg <= wr_fill;
            end
            else if (valid_reg[rd_idx])
            begin
                rd_cnt_reg  <= cnt_mem[rd_idx];
                rd_head_reg <= head_mem[rd_idx];
                rd_fill_reg <= fill_mem[rd_idx];
            end
            else
            begin
                rd_cnt_reg  <= init_reg;
                rd_head_reg <= '0;
                rd_fill_reg <= '0;
            end
        end
    end

    assign rd_cnt  = rd_cnt_reg;
    assign rd_head = rd_head_reg;
    assign rd_fill = rd_fill_reg;

endmodule

// ===== hw/rtl/csbf_wait_mem.sv =====
module csbf_wait_mem #(
    parameter int NUM_SEMAPHORES = csbf_pkg::DEF_NUM_SEMAPHORES,
    parameter int QUEUE_DEPTH    = csbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [$clog2(NUM_SEMAPHORES * QUEUE_DEPTH > 1 ?
                         NUM_SEMAPHORES * QUEUE_DEPTH : 2)-1:0] waddr,
    input  logic [7:0]             wdata,
    input  logic                   re,
    input  logic [$clog2(NUM_SEMAPHORES * QUEUE_DEPTH > 1 ?
                         NUM_SEMAPHORES * QUEUE_DEPTH : 2)-1:0] raddr,
    output logic [7:0]             rdata
);

    localparam int ENTRIES = NUM_SEMAPHORES * QUEUE_DEPTH;

    logic [7:0] mem [ENTRIES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/csbf_step.sv =====
module csbf_step #(
    parameter int NUM_SEMAPHORES = csbf_pkg::DEF_NUM_SEMAPHORES,
    parameter int QUEUE_DEPTH    = csbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               kind,
    input  logic [2:0]                         sem_index,
    input  logic [7:0]                         requester_id,
    input  logic [7:0]                         cnt,
    input  logic [$clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2)-1:0] head,
    input  logic [$clog2(QUEUE_DEPTH + 1)-1:0] fill,
    output csbf_pkg::csbf_ctrl_t               ctrl,
    output logic [$clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2)-1:0] st_idx,
    output logic [7:0]                         new_cnt,
    output logic [$clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2)-1:0] new_head,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0] new_fill,
    output logic [$clog2(NUM_SEMAPHORES * QUEUE_DEPTH > 1 ?
                         NUM_SEMAPHORES * QUEUE_DEPTH : 2)-1:0] q_addr,
    output logic [7:0]                         q_wdata,
    output logic [7:0]                         count_after
);

    localparam int SW = $clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2);
    localparam int HW = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH > 1 ?
                               NUM_SEMAPHORES * QUEUE_DEPTH : 2);

    logic [csbf_pkg::IDX_EXT_W-1:0] idx_ext;
    logic                           in_range;
    logic [FW:0]                    tail_sum;
    logic [HW-1:0]                  tail_slot;
    logic [HW-1:0]                  head_inc;
    logic [HW-1:0]                  slot;

    assign idx_ext  = csbf_pkg::IDX_EXT_W'(sem_index);
    assign in_range = idx_ext < csbf_pkg::IDX_EXT_W'(NUM_SEMAPHORES);
    assign st_idx   = idx_ext[SW-1:0];

    // Tail slot wraps around the ring of this semaphore
    assign tail_sum  = (FW + 1)'(head) + (FW + 1)'(fill);
    assign tail_slot = (tail_sum >= (FW + 1)'(QUEUE_DEPTH)) ?
                       HW'(tail_sum - (FW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    assign head_inc  = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);

    assign slot    = (kind == csbf_pkg::KIND_WAIT) ? tail_slot : head;
    assign q_addr  = AW'(st_idx) * AW'(QUEUE_DEPTH) + AW'(slot);
    assign q_wdata = requester_id;

    always_comb
    begin
        ctrl.st_write = 1'b0;
        ctrl.q_write  = 1'b0;
        ctrl.q_read   = 1'b0;
        ctrl.status   = csbf_pkg::ST_FULL;
        new_cnt       = cnt;
        new_head      = head;
        new_fill      = fill;
        if (in_range)
        begin
            if (kind == csbf_pkg::KIND_WAIT)
            begin
                if (cnt != 8'd0)
                begin
                    new_cnt       = cnt - 8'd1;
                    ctrl.st_write = 1'b1;
                    ctrl.status   = csbf_pkg::ST_GRANTED;
                end
                else if (fill < FW'(QUEUE_DEPTH))
                begin
                    new_fill      = fill + FW'(1);
                    ctrl.st_write = 1'b1;
                    ctrl.q_write  = 1'b1;
                    ctrl.status   = csbf_pkg::ST_QUEUED;
                end
            end
            else
            begin
                if (fill != '0)
                begin
                    new_head      = head_inc;
                    new_fill      = fill - FW'(1);
                    ctrl.st_write = 1'b1;
                    ctrl.q_read   = 1'b1;
                    ctrl.status   = csbf_pkg::ST_HANDOFF;
                end
                else if (cnt == csbf_pkg::COUNT_MAX)
                begin
                    ctrl.status = csbf_pkg::ST_SATURATED;
                end
                else
                begin
                    new_cnt       = cnt + 8'd1;
                    ctrl.st_write = 1'b1;
                    ctrl.status   = csbf_pkg::ST_INCREMENT;
                end
            end
        end
    end

    assign count_after = (ctrl.status == csbf_pkg::ST_FULL) ? 8'd0 : new_cnt;

endmodule

// ===== hw/rtl/counting_semaphore_bank_fifo_top.sv =====
// Channel   Direction  Signals                                 Moves
// req       in         req_valid/req_ready, kind, sem_index,   one wait or signal request
//                      requester_id
// rsp       out        rsp_valid/rsp_ready, status, woken_id,  one result per request
//                      count_after
// cfg       in         cfg_valid/cfg_ready, initial_count      bank reload value
//
// One request per cycle unless rsp stalls; rsp_valid is set as stage one advances.
// Stage one reads the addressed semaphore's count, head and fill from the state memory
// (same-index updates are forwarded), stage two holds the result and the waiter read.
// Reset loads every count with INIT_COUNT_RESET, a cfg write with initial_count; both
// empty every queue at once through per-semaphore valid bits; no clearing pass.
// A stalled rsp holds both stages; req_ready drops only when stage one cannot advance.
module counting_semaphore_bank_fifo_top #(
    parameter int NUM_SEMAPHORES = csbf_pkg::DEF_NUM_SEMAPHORES,
    parameter int QUEUE_DEPTH    = csbf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       kind,
    input  logic [2:0] sem_index,
    input  logic [7:0] requester_id,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [2:0] status,
    output logic [7:0] woken_id,
    output logic [7:0] count_after,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] initial_count
);

    localparam int SW = $clog2(NUM_SEMAPHORES > 1 ? NUM_SEMAPHORES : 2);
    localparam int HW = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH > 1 ?
                               NUM_SEMAPHORES * QUEUE_DEPTH : 2);

    logic       s1_valid_reg;
    logic       s1_kind_reg;
    logic [2:0] s1_idx_reg;
    logic [7:0] s1_rid_reg;

    logic                   rsp_valid_reg;
    csbf_pkg::csbf_status_t status_reg;
    logic [7:0]             count_reg;
    logic                   handoff_reg;

    logic s1_adv;
    logic accept;
    logic cfg_we;

    logic [csbf_pkg::IDX_EXT_W-1:0] rd_ext;
    logic [SW-1:0]                  rd_idx;

    logic [7:0]    cur_cnt;
    logic [HW-1:0] cur_head;
    logic [FW-1:0] cur_fill;

    csbf_pkg::csbf_ctrl_t ctrl;
    logic [SW-1:0]        st_idx;
    logic [7:0]           new_cnt;
    logic [HW-1:0]        new_head;
    logic [FW-1:0]        new_fill;
    logic [AW-1:0]        q_addr;
    logic [7:0]           q_wdata;
    logic [7:0]           step_count;
    logic [7:0]           wq_rdata;

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign rd_ext = csbf_pkg::IDX_EXT_W'(sem_index);
    assign rd_idx = rd_ext[SW-1:0];

    csbf_state_mem #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_state_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (initial_count),
        .rd_en    (accept),
        .rd_idx   (rd_idx),
        .rd_cnt   (cur_cnt),
        .rd_head  (cur_head),
        .rd_fill  (cur_fill),
        .wr_en    (s1_adv && ctrl.st_write),
        .wr_idx   (st_idx),
        .wr_cnt   (new_cnt),
        .wr_head  (new_head),
        .wr_fill  (new_fill)
    );

    csbf_step #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_step (
        .kind         (s1_kind_reg),
        .sem_index    (s1_idx_reg),
        .requester_id (s1_rid_reg),
        .cnt          (cur_cnt),
        .head         (cur_head),
        .fill         (cur_fill),
        .ctrl         (ctrl),
        .st_idx       (st_idx),
        .new_cnt      (new_cnt),
        .new_head     (new_head),
        .new_fill     (new_fill),
        .q_addr       (q_addr),
        .q_wdata      (q_wdata),
        .count_after  (step_count)
    );

    csbf_wait_mem #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_wait_mem (
        .clk   (clk),
        .we    (s1_adv && ctrl.q_write),
        .waddr (q_addr),
        .wdata (q_wdata),
        .re    (s1_adv && ctrl.q_read),
        .raddr (q_addr),
        .rdata (wq_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_idx_reg  <= sem_index;
            s1_rid_reg  <= requester_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the result while the response side stalls
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg  <= ctrl.status;
            count_reg   <= step_count;
            handoff_reg <= ctrl.q_read;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign count_after = count_reg;
    assign woken_id    = handoff_reg ? wq_rdata : 8'd0;

endmodule

// ===== test/counting_semaphore_bank_fifo_checker.sv =====
module counting_semaphore_bank_fifo_checker
    import csbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic       kind,
    input  logic [2:0] sem_index,
    input  logic [7:0] requester_id,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic [2:0] status,
    input  logic [7:0] woken_id,
    input  logic [7:0] count_after,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] initial_count,
    output int         outstanding,
    output int         fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEMS  = DEF_NUM_SEMAPHORES;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        csbf_status_t status;
        logic [7:0]   woken;
        logic [7:0]   count;
    } sem_result_t;

    logic [7:0]  reload_value;
    logic [7:0]  counts [SEMS];
    logic [7:0]  waiters [SEMS][DEPTH];
    logic [2:0]  heads [SEMS];
    logic [3:0]  fills [SEMS];
    sem_result_t pending_results [$];
    int          errors = 0;

    assign fail_count = errors;

    task automatic flag(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic reload_bank();
        for (int s = 0; s < SEMS; s++)
        begin
            counts[s] = reload_value;
            heads[s]  = '0;
            fills[s]  = '0;
        end
    endtask

    function automatic sem_result_t apply_request(input logic k, input logic [2:0] idx,
                                                  input logic [7:0] rid);
        sem_result_t r;
        logic [2:0]  slot;
        r.woken = '0;
        if (k == KIND_WAIT)
        begin
            if (counts[idx] != 8'd0)
            begin
                counts[idx] = counts[idx] - 8'd1;
                r.status = ST_GRANTED;
            end
            else if (fills[idx] < DEPTH)
            begin
                // tail slot wraps modulo the queue depth
                slot = heads[idx] + fills[idx][2:0];
                waiters[idx][slot] = rid;
                fills[idx] = fills[idx] + 4'd1;
                r.status = ST_QUEUED;
            end
            else
            begin
                r.status = ST_FULL;
            end
        end
        else
        begin
            if (fills[idx] != 4'd0)
            begin
                r.woken = waiters[idx][heads[idx]];
                heads[idx] = heads[idx] + 3'd1;
                fills[idx] = fills[idx] - 4'd1;
                r.status = ST_HANDOFF;
            end
            else if (counts[idx] >= COUNT_MAX)
            begin
                r.status = ST_SATURATED;
            end
            else
            begin
                counts[idx] = counts[idx] + 8'd1;
                r.status = ST_INCREMENT;
            end
        end
        r.count = (r.status == ST_FULL) ? 8'd0 : counts[idx];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sem_result_t want;
        if (!rst_n)
        begin
            reload_value = INIT_COUNT_RESET;
            reload_bank();
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    flag($sformatf("response with no request pending: status %0d id %0d count %0d",
                                   status, woken_id, count_after));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        flag($sformatf("status %0d, expected %0d", status, want.status));
                    if (woken_id !== want.woken)
                        flag($sformatf("woken_id %0d, expected %0d", woken_id, want.woken));
                    if (count_after !== want.count)
                        flag($sformatf("count_after %0d, expected %0d", count_after, want.count));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                reload_value = initial_count;
                reload_bank();
            end
            if (req_valid && req_ready)
                pending_results.push_back(apply_request(kind, sem_index, requester_id));
            outstanding <= outstanding + int'(req_valid && req_ready)
                                       - int'(rsp_valid && rsp_ready);
        end
    end

endmodule

// ===== test/counting_semaphore_bank_fifo_top_tb.sv =====
module counting_semaphore_bank_fifo_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import csbf_pkg::*;

    localparam int PHASES     = 6;
    localparam int PHASE_REQS = 272;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic       kind = 1'b0;
    logic [2:0] sem_index = '0;
    logic [7:0] requester_id = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [2:0] status;
    logic [7:0] woken_id;
    logic [7:0] count_after;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] initial_count = INIT_COUNT_RESET;

    int outstanding;
    int fail_count;
    int idle_pct = 0;
    int stall_pct = 0;

    counting_semaphore_bank_fifo_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .kind         (kind),
        .sem_index    (sem_index),
        .requester_id (requester_id),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .woken_id     (woken_id),
        .count_after  (count_after),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .initial_count(initial_count)
    );

    counting_semaphore_bank_fifo_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .kind         (kind),
        .sem_index    (sem_index),
        .requester_id (requester_id),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .woken_id     (woken_id),
        .count_after  (count_after),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .initial_count(initial_count),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_req(input logic k, input logic [2:0] idx, input logic [7:0] rid);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        kind         <= k;
        sem_index    <= idx;
        requester_id <= rid;
        do @(posedge clk); while (!req_ready);
    endtask

    // drain every pending response, then reload the bank
    task automatic write_config(input logic [7:0] value);
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid     <= 1'b1;
        initial_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int quota);
        int         sent;
        int         len;
        logic       k;
        logic [2:0] idx;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 60)
            begin
                // burst on one semaphore: fill or drain its queue, push toward saturation
                k   = 1'($urandom_range(1));
                idx = 3'($urandom_range(7));
                len = $urandom_range(1, 12);
                for (int i = 0; i < len && sent < quota; i++)
                begin
                    send_req(k, idx, 8'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_req(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [7:0] cfg_values [PHASES];
        cfg_values[0] = INIT_COUNT_RESET;
        cfg_values[1] = 8'd0;
        cfg_values[2] = COUNT_MAX;
        cfg_values[3] = 8'($urandom_range(3, 254));
        cfg_values[4] = 8'd2;
        cfg_values[5] = 8'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one grant, eight queued waiters, then a full queue
        send_req(KIND_WAIT, 3'd0, 8'hFF);
        send_req(KIND_WAIT, 3'd0, 8'h00);
        for (int i = 1; i < 8; i++)
            send_req(KIND_WAIT, 3'd0, 8'(i * 37));
        send_req(KIND_WAIT, 3'd0, 8'h81);
        // wake all eight in order, then bump the count
        for (int i = 0; i < 9; i++)
            send_req(KIND_SIGNAL, 3'd0, 8'h55);
        send_req(KIND_SIGNAL, 3'd7, 8'hAA);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            if (p > 0)
                write_config(cfg_values[p]);
            if (cfg_values[p] == COUNT_MAX)
            begin
                send_req(KIND_SIGNAL, 3'd3, 8'h5A);
                send_req(KIND_WAIT, 3'd3, 8'h01);
                send_req(KIND_SIGNAL, 3'd3, 8'hFE);
            end
            random_traffic(PHASE_REQS);
        end

        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS counting_semaphore_bank_fifo_top");
        else
            $display("FAIL counting_semaphore_bank_fifo_top");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL counting_semaphore_bank_fifo_top");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/csbf_pkg.sv
hw/rtl/csbf_state_mem.sv
hw/rtl/csbf_wait_mem.sv
hw/rtl/csbf_step.sv
hw/rtl/counting_semaphore_bank_fifo_top.sv
test/counting_semaphore_bank_fifo_checker.sv
test/counting_semaphore_bank_fifo_top_tb.sv
